### src/differential_drive_odometry_assert.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shorthand for clocked implication checks on clock / reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers of the differential drive odometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int POS_FRAC_DEF     = 16;
   localparam int ATAN_LEN         = 30;
   localparam int CNT_W            = 5;
   localparam int TMAG_W           = 54;
   localparam int ACC_W            = 80;

   localparam logic [31:0] MPC_RESET  = 32'd429497;
   localparam logic [23:0] IWB_RESET  = 24'd218453;
   localparam logic [15:0] RATE_RESET = 16'd100;

   localparam logic [1:0] CSR_MPC  = 2'd0;
   localparam logic [1:0] CSR_IWB  = 2'd1;
   localparam logic [1:0] CSR_RATE = 2'd2;

   localparam logic signed [35:0] PI_Q28      = 36'sd843314857;
   localparam logic signed [35:0] TWO_PI_Q28  = 36'sd1686629714;
   localparam logic [31:0]        FOUR_PI_Q28 = 32'd3373259428;
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
   // floor(2^63 / 4pi_q28): quotient estimate of the heading reduction
   localparam logic [31:0]        RECIP_4PI   =
      32'(64'h8000_0000_0000_0000 / 64'd3373259428);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLEAR, ST_SUM, ST_KMUL, ST_KQ, ST_TLO, ST_THI, ST_TACC, ST_TMAG,
      ST_QEST, ST_QMUL, ST_MOD, ST_MODFIX, ST_ANG, ST_CINIT, ST_CSTEP, ST_TRIG,
      ST_XLO, ST_XHI, ST_YLO, ST_YHI, ST_LLO, ST_LHI, ST_RLO, ST_RHI, ST_RACC,
      ST_COMMIT, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_CLEAR, DP_SMAG, DP_KQ, DP_TMAG, DP_MOD, DP_MODFIX, DP_ANG,
      DP_CINIT, DP_CSTEP, DP_TRIG, DP_FINX, DP_FINY, DP_FINLIN, DP_FINTURN
   } dp_op_type;

   typedef enum logic [3:0] {
      MS_NONE, MS_SUM, MS_K, MS_TLO, MS_THI, MS_QEST, MS_QMUL, MS_XLO, MS_XHI,
      MS_YLO, MS_YHI, MS_LLO, MS_LHI, MS_RLO, MS_RHI
   } msel_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_type;

   typedef struct packed {
      dp_op_type          op;
      msel_type           msel;
      acc_type            acc;
      logic [CNT_W-1:0]   iter;
   } dp_cmd_type;

   typedef struct packed {
      logic start;
      logic clear_op;
      logic out_free;
   } hs_in_type;

   typedef struct packed {
      logic idle;
      logic deliver;
   } hs_out_type;

   typedef struct packed {
      logic signed [31:0] turn_rate;
      logic signed [31:0] linear_speed;
      logic signed [30:0] heading;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
   } res_type;

   function automatic logic [30:0] atan_q30(input logic [CNT_W-1:0] idx);
      logic [30:0] v;
      case (idx)
         5'd0:  v = 31'd843314856;
         5'd1:  v = 31'd497837829;
         5'd2:  v = 31'd263043836;
         5'd3:  v = 31'd133525158;
         5'd4:  v = 31'd67021686;
         5'd5:  v = 31'd33543515;
         5'd6:  v = 31'd16775850;
         5'd7:  v = 31'd8388437;
         5'd8:  v = 31'd4194282;
         5'd9:  v = 31'd2097149;
         5'd10: v = 31'd1048575;
         5'd11: v = 31'd524287;
         5'd12: v = 31'd262143;
         5'd13: v = 31'd131071;
         5'd14: v = 31'd65535;
         5'd15: v = 31'd32767;
         5'd16: v = 31'd16383;
         5'd17: v = 31'd8191;
         5'd18: v = 31'd4095;
         5'd19: v = 31'd2047;
         5'd20: v = 31'd1023;
         5'd21: v = 31'd511;
         5'd22: v = 31'd255;
         5'd23: v = 31'd127;
         5'd24: v = 31'd63;
         5'd25: v = 31'd31;
         5'd26: v = 31'd15;
         5'd27: v = 31'd8;
         5'd28: v = 31'd4;
         5'd29: v = 31'd2;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

   // magnitude plus sign into a saturated 32-bit word
   function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
      logic signed [31:0] v;
      if (neg) begin
         v = (mag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-mag);
      end else begin
         v = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag);
      end
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // fold an angle plus pi lying in (-2pi, 4pi) back into [-pi, pi)
   function automatic logic signed [30:0] wrap_q28(input logic signed [35:0] t);
      logic signed [35:0] u;
      if (t < 0) begin
         u = t + TWO_PI_Q28;
      end else if (t >= TWO_PI_Q28) begin
         u = t - TWO_PI_Q28;
      end else begin
         u = t;
      end
      u = u - PI_Q28;
      return u[30:0];
   endfunction

endpackage

### src/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry for a two-wheel robot: pose and speeds from encoder deltas.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per sample period. req_tuser set clears the pose to
//            zero; clear otherwise, and req_tdata carries left_delta (low 16)
//            and right_delta (high 16), signed encoder counts.
//   rsp_*  : one word per request: pos_x, pos_y (Q16.16), heading (Q3.28),
//            linear_speed and turn_rate (Q16.16).
//   csr_*  : register writes, always ready; index 0 metres per count,
//            1 inverse wheel base, 2 update rate. Other indexes are dropped.
// Timing: the cost of an update is set by the CORDIC rotations and fourteen
//   passes through the single 32x32 multiplier, two of them for the reciprocal
//   heading reduction. One word is in flight at a time; the next is taken once
//   the sequencer is back in idle after a result moves into the output
//   register.
// Reset: pose zero, registers to their defaults, no result pending.
// Stall: a result waits in the output register while rsp_tready is low; a
//   finished update behind it holds until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_odometry #(
   parameter int CORDIC_STEPS           = ddo_pkg::CORDIC_STEPS_DEF,
   parameter int POSITION_FRACTION_BITS = ddo_pkg::POS_FRAC_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // left_delta, right_delta
   input  logic         req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // pos_x, pos_y, heading, linear_speed, turn_rate, pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import ddo_pkg::*;

   logic [31:0]  mpc_ff;
   logic [23:0]  iwb_ff;
   logic [15:0]  rate_ff;
   logic         rsp_valid_ff;
   logic [159:0] rsp_data_ff;

   hs_in_type  hs_in;
   hs_out_type hs_out;
   dp_cmd_type cmd;
   res_type    res;

   // Configuration: always ready, ignore unknown indexes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mpc_ff  <= MPC_RESET;
         iwb_ff  <= IWB_RESET;
         rate_ff <= RATE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MPC:  mpc_ff  <= csr_data;
            CSR_IWB:  iwb_ff  <= csr_data[23:0];
            CSR_RATE: rate_ff <= csr_data[15:0];
            default:  ;
         endcase
      end
   end

   // Handshake glue between the ports and the sequencer.
   assign req_tready     = hs_out.idle;
   assign hs_in.start    = req_tvalid & hs_out.idle;
   assign hs_in.clear_op = req_tuser;
   assign hs_in.out_free = ~rsp_valid_ff | rsp_tready;

   ddo_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .hs_in  (hs_in),
      .hs_out (hs_out),
      .cmd    (cmd)
   );

   ddo_dpath #(
      .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .mpc         (mpc_ff),
      .iwb         (iwb_ff),
      .rate        (rate_ff),
      .left_delta  (req_tdata[15:0]),
      .right_delta (req_tdata[31:16]),
      .res         (res)
   );

   // Output register: load on deliver, drop when the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (hs_out.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hs_out.deliver) begin
         rsp_data_ff <= {1'b0, res.turn_rate, res.linear_speed, res.heading,
                         res.pos_y, res.pos_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: walks the datapath through one odometry update or pose clear per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "differential_drive_odometry_assert.svh"

module ddo_ctrl #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ddo_pkg::hs_in_type  hs_in,
   output ddo_pkg::hs_out_type hs_out,
   output ddo_pkg::dp_cmd_type cmd
);
   import ddo_pkg::*;

   localparam int CSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam logic [CNT_W-1:0] CLAST    = CNT_W'(CSTEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = '0;
      cmd.op         = DP_NOP;
      cmd.msel       = MS_NONE;
      cmd.acc        = ACC_HOLD;
      cmd.iter       = cnt_ff;
      hs_out.idle    = 1'b0;
      hs_out.deliver = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            hs_out.idle = 1'b1;
            if (hs_in.start) begin
               cmd.op   = DP_LOAD;
               state_in = hs_in.clear_op ? ST_CLEAR : ST_SUM;
            end
         end
         ST_CLEAR: begin
            cmd.op   = DP_CLEAR;
            state_in = ST_DONE;
         end
         ST_SUM: begin
            cmd.msel = MS_SUM;
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            cmd.msel = MS_K;
            cmd.op   = DP_SMAG;
            state_in = ST_KQ;
         end
         ST_KQ: begin
            cmd.op   = DP_KQ;
            state_in = ST_TLO;
         end
         ST_TLO: begin
            cmd.msel = MS_TLO;
            state_in = ST_THI;
         end
         ST_THI: begin
            cmd.msel = MS_THI;
            cmd.acc  = ACC_LOAD;
            state_in = ST_TACC;
         end
         ST_TACC: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_TMAG;
         end
         ST_TMAG: begin
            cmd.op   = DP_TMAG;
            state_in = ST_QEST;
         end
         ST_QEST: begin
            cmd.msel = MS_QEST;
            state_in = ST_QMUL;
         end
         ST_QMUL: begin
            cmd.msel = MS_QMUL;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.op   = DP_MOD;
            state_in = ST_MODFIX;
         end
         ST_MODFIX: begin
            cmd.op   = DP_MODFIX;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            cmd.op   = DP_ANG;
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            cmd.op   = DP_CINIT;
            state_in = ST_CSTEP;
         end
         ST_CSTEP: begin
            cmd.op = DP_CSTEP;
            if (cnt_ff == CLAST) begin
               state_in = ST_TRIG;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_TRIG: begin
            cmd.op   = DP_TRIG;
            state_in = ST_XLO;
         end
         ST_XLO: begin
            cmd.msel = MS_XLO;
            state_in = ST_XHI;
         end
         ST_XHI: begin
            cmd.msel = MS_XHI;
            cmd.acc  = ACC_LOAD;
            state_in = ST_YLO;
         end
         ST_YLO: begin
            cmd.msel = MS_YLO;
            cmd.acc  = ACC_ADD;
            state_in = ST_YHI;
         end
         ST_YHI: begin
            cmd.msel = MS_YHI;
            cmd.op   = DP_FINX;
            cmd.acc  = ACC_LOAD;
            state_in = ST_LLO;
         end
         ST_LLO: begin
            cmd.msel = MS_LLO;
            cmd.acc  = ACC_ADD;
            state_in = ST_LHI;
         end
         ST_LHI: begin
            cmd.msel = MS_LHI;
            cmd.op   = DP_FINY;
            cmd.acc  = ACC_LOAD;
            state_in = ST_RLO;
         end
         ST_RLO: begin
            cmd.msel = MS_RLO;
            cmd.acc  = ACC_ADD;
            state_in = ST_RHI;
         end
         ST_RHI: begin
            cmd.msel = MS_RHI;
            cmd.op   = DP_FINLIN;
            cmd.acc  = ACC_LOAD;
            state_in = ST_RACC;
         end
         ST_RACC: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.op   = DP_FINTURN;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (hs_in.out_free) begin
               hs_out.deliver = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `DDO_ASSERT_HOLDS(a_start_idle, hs_in.start, state_ff == ST_IDLE, "word taken while busy")
   `DDO_ASSERT_NEXT(a_cordic_end, state_ff == ST_CSTEP && cnt_ff == CLAST, state_ff == ST_TRIG, "rotation count off")
   `DDO_ASSERT_NEXT(a_mod_fix, state_ff == ST_MOD, state_ff == ST_MODFIX, "reduction skipped")
   `DDO_ASSERT_NEXT(a_done_hold, state_ff == ST_DONE && !hs_in.out_free, state_ff == ST_DONE, "result dropped under stall")
   `DDO_ASSERT_HOLDS(a_idle_cnt, state_ff == ST_IDLE, cnt_ff == '0, "counter not cleared")

endmodule

### src/ddo_dpath.sv
// ----------------------------------------------------------------------------
// ddo_dpath
// Datapath: shared multiplier, heading reduction, CORDIC and pose registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_dpath #(
   parameter int POSITION_FRACTION_BITS = ddo_pkg::POS_FRAC_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ddo_pkg::dp_cmd_type cmd,
   input  logic [31:0]         mpc,
   input  logic [23:0]         iwb,
   input  logic [15:0]         rate,
   input  logic signed [15:0]  left_delta,
   input  logic signed [15:0]  right_delta,
   output ddo_pkg::res_type    res
);
   import ddo_pkg::*;

   localparam int SHIFT = 63 - POSITION_FRACTION_BITS;

   logic signed [16:0]  sumc_ff, diffc_ff;
   logic [16:0]         sum_abs, dmag;
   logic                sneg, dneg;
   logic [47:0]         smag_ff;
   logic [44:0]         kq_ff;
   logic [TMAG_W-1:0]   tmag_ff;
   logic [32:0]         rdiff_ff;
   logic [31:0]         rem_ff;
   logic signed [30:0]  yaw_ff, mid_ff;
   logic signed [31:0]  x_ff, y_ff, lin_ff, turn_ff;
   logic signed [35:0]  cx_ff, cy_ff, cz_ff;
   logic                fold_ff, cneg_ff, tneg_ff;
   logic [31:0]         cabs_ff, sabs_ff;
   logic [31:0]         mul_a, mul_b;
   logic [63:0]         prod_ff;
   logic [ACC_W-1:0]    acc_ff, prod_hi;

   assign sum_abs = sumc_ff[16] ? 17'(-sumc_ff) : 17'(sumc_ff);
   assign dmag    = diffc_ff[16] ? 17'(-diffc_ff) : 17'(diffc_ff);
   assign sneg    = sumc_ff[16];
   assign dneg    = diffc_ff[16];
   assign prod_hi = {prod_ff[ACC_W-33:0], 32'd0};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.msel)
         MS_SUM:  begin mul_a = {15'd0, sum_abs};        mul_b = mpc;           end
         MS_K:    begin mul_a = mpc;                     mul_b = {8'd0, iwb};   end
         MS_TLO:  begin mul_a = kq_ff[31:0];             mul_b = {15'd0, dmag}; end
         MS_THI:  begin mul_a = {19'd0, kq_ff[44:32]};   mul_b = {15'd0, dmag}; end
         MS_QEST: begin mul_a = tmag_ff[TMAG_W-1:TMAG_W-32]; mul_b = RECIP_4PI; end
         MS_QMUL: begin mul_a = {9'd0, prod_ff[63:41]};  mul_b = FOUR_PI_Q28;   end
         MS_XLO:  begin mul_a = smag_ff[31:0];           mul_b = cabs_ff;       end
         MS_XHI:  begin mul_a = {16'd0, smag_ff[47:32]}; mul_b = cabs_ff;       end
         MS_YLO:  begin mul_a = smag_ff[31:0];           mul_b = sabs_ff;       end
         MS_YHI:  begin mul_a = {16'd0, smag_ff[47:32]}; mul_b = sabs_ff;       end
         MS_LLO:  begin mul_a = smag_ff[31:0];           mul_b = {16'd0, rate}; end
         MS_LHI:  begin mul_a = {16'd0, smag_ff[47:32]}; mul_b = {16'd0, rate}; end
         MS_RLO:  begin mul_a = tmag_ff[31:0];           mul_b = {16'd0, rate}; end
         MS_RHI:  begin mul_a = {20'd0, tmag_ff[43:32]}; mul_b = {16'd0, rate}; end
         default: ;
      endcase
   end

   // rounding of the products
   logic [63:0]        kq_t;
   logic [ACC_W-1:0]   tm_t, lin_t, turn_t, adv_q;
   logic signed [63:0] adv_m, x_sum, y_sum;
   logic               xneg, yneg;

   assign kq_t   = prod_ff + 64'd2048;
   assign tm_t   = acc_ff + ACC_W'(128);
   assign lin_t  = acc_ff + ACC_W'(65536);
   assign turn_t = acc_ff + ACC_W'(2048);
   assign adv_q  = (acc_ff >> SHIFT) + ACC_W'(acc_ff[SHIFT-1]);
   assign adv_m  = adv_q[63:0];
   assign xneg   = sneg ^ cneg_ff;
   assign yneg   = sneg ^ tneg_ff;
   assign x_sum  = {{32{x_ff[31]}}, x_ff} + (xneg ? -adv_m : adv_m);
   assign y_sum  = {{32{y_ff[31]}}, y_ff} + (yneg ? -adv_m : adv_m);

   logic signed [31:0] turn_in;
   always_comb begin
      if (rate == 16'd0) begin
         turn_in = '0;
      end else if (|tmag_ff[TMAG_W-1:44]) begin
         turn_in = sat_mag(64'd1 << 40, dneg);
      end else begin
         turn_in = sat_mag(turn_t[75:12], dneg);
      end
   end

   // heading reduction modulo 4pi: the reciprocal estimate of the quotient is
   // exact or one short, so one subtract of the product and one compare and
   // subtract leave the remainder
   logic [TMAG_W-1:0] rdiff_t;
   logic [32:0]       rfix;
   assign rdiff_t = tmag_ff - prod_ff[TMAG_W-1:0];
   assign rfix    = (rdiff_ff >= {1'b0, FOUR_PI_Q28}) ? rdiff_ff - {1'b0, FOUR_PI_Q28}
                                                      : rdiff_ff;

   // midpoint and new yaw from the reduced change
   logic signed [35:0] yaw_ext, half_ext, rem_ext, full_ext;
   logic signed [30:0] mid_in, yaw_in;
   assign yaw_ext  = {{5{yaw_ff[30]}}, yaw_ff};
   assign half_ext = {5'd0, rem_ff[31:1]};
   assign rem_ext  = {4'd0, rem_ff};
   assign full_ext = (rem_ext >= TWO_PI_Q28) ? rem_ext - TWO_PI_Q28 : rem_ext;
   assign mid_in   = wrap_q28(yaw_ext + PI_Q28 + (dneg ? -half_ext : half_ext));
   assign yaw_in   = wrap_q28(yaw_ext + PI_Q28 + (dneg ? -full_ext : full_ext));

   // CORDIC
   logic signed [35:0] z0, z_in, xs, ys, at, c_fin, s_fin;
   logic               fold_in;
   always_comb begin
      z0      = {{3{mid_ff[30]}}, mid_ff, 2'b00};
      z_in    = z0;
      fold_in = 1'b0;
      if (z0 > HALF_PI_Q30) begin
         z_in    = z0 - PI_Q30;
         fold_in = 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
         z_in    = z0 + PI_Q30;
         fold_in = 1'b1;
      end
   end
   assign xs    = cx_ff >>> cmd.iter;
   assign ys    = cy_ff >>> cmd.iter;
   assign at    = {5'd0, atan_q30(cmd.iter)};
   assign c_fin = fold_ff ? -cx_ff : cx_ff;
   assign s_fin = fold_ff ? -cy_ff : cy_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd.acc)
         ACC_LOAD: acc_ff <= {16'd0, prod_ff};
         ACC_ADD:  acc_ff <= acc_ff + prod_hi;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         y_ff   <= '0;
         yaw_ff <= '0;
      end else begin
         unique case (cmd.op)
            DP_LOAD: begin
               sumc_ff  <= 17'(left_delta) + 17'(right_delta);
               diffc_ff <= 17'(right_delta) - 17'(left_delta);
            end
            DP_CLEAR: begin
               x_ff    <= '0;
               y_ff    <= '0;
               yaw_ff  <= '0;
               lin_ff  <= '0;
               turn_ff <= '0;
            end
            DP_SMAG:   smag_ff  <= prod_ff[47:0];
            DP_KQ:     kq_ff    <= kq_t[56:12];
            DP_TMAG:   tmag_ff  <= tm_t[TMAG_W+7:8];
            DP_MOD:    rdiff_ff <= rdiff_t[32:0];
            DP_MODFIX: rem_ff   <= rfix[31:0];
            DP_ANG: begin
               mid_ff <= mid_in;
               yaw_ff <= yaw_in;
            end
            DP_CINIT: begin
               cx_ff   <= GAIN_Q30;
               cy_ff   <= '0;
               cz_ff   <= z_in;
               fold_ff <= fold_in;
            end
            DP_CSTEP: begin
               if (!cz_ff[35]) begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - at;
               end else begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + at;
               end
            end
            DP_TRIG: begin
               cneg_ff <= c_fin[35];
               tneg_ff <= s_fin[35];
               cabs_ff <= c_fin[35] ? 32'(-c_fin) : c_fin[31:0];
               sabs_ff <= s_fin[35] ? 32'(-s_fin) : s_fin[31:0];
            end
            DP_FINX:    x_ff    <= sat32(x_sum);
            DP_FINY:    y_ff    <= sat32(y_sum);
            DP_FINLIN:  lin_ff  <= sat_mag({1'b0, lin_t[ACC_W-1:17]}, sneg);
            DP_FINTURN: turn_ff <= turn_in;
            default: ;
         endcase
      end
   end

   assign res.pos_x        = x_ff;
   assign res.pos_y        = y_ff;
   assign res.heading      = yaw_ff;
   assign res.linear_speed = lin_ff;
   assign res.turn_rate    = turn_ff;

endmodule
